FILE: rtl/vigc_pkg.sv
// Shared types, constants and character arithmetic for the offset cipher.
package vigc_pkg;

    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int LEN_W     = 9;
    localparam int OFS_W     = 5;
    localparam int CHAR_W    = 7;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [LEN_W-1:0]  KEY_DEPTH_LEN = LEN_W'(KEY_DEPTH);
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 7'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP = 7'h20;
    localparam logic [OFS_W-1:0]  ALPHA    = 5'd26;

    typedef enum logic [0:0] {
        OP_CHAR = 1'b0,
        OP_KEY  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        CFG_DECRYPT_MODE = 1'b0,
        CFG_KEY_LENGTH   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        logic [OFS_W-1:0]  data;
    } key_wr_t;

    function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
        return (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_CR);
    endfunction

    // truncated remainder mod 26 of s (|s| <= 90), then + 'A'
    function automatic logic [CHAR_W-1:0] mod26_char(input logic signed [7:0] s);
        logic [6:0] mag;
        logic [6:0] rem;
        mag = (s < 0) ? 7'(-s) : 7'(s);
        priority if (mag >= 7'd78)
            rem = mag - 7'd78;
        else if (mag >= 7'd52)
            rem = mag - 7'd52;
        else if (mag >= 7'd26)
            rem = mag - 7'd26;
        else
            rem = mag;
        return (s < 0) ? (CH_A - rem) : (CH_A + rem);
    endfunction

endpackage

FILE: rtl/vigc_key_ram.sv
// Key offset table: one write port, one registered read port.
module vigc_key_ram (
    input  logic                              clk,
    input  vigc_pkg::key_wr_t                 wr,
    input  logic                              rd_en,
    input  logic [vigc_pkg::KEY_AW-1:0]       rd_addr,
    output logic [vigc_pkg::OFS_W-1:0]        rd_data
);

    logic [vigc_pkg::OFS_W-1:0] mem [vigc_pkg::KEY_DEPTH];
    logic [vigc_pkg::OFS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/vigc_shift.sv
// Character shift unit: upper-case, add or subtract key offset mod 26; blanks pass unchanged.
module vigc_shift (
    input  logic [vigc_pkg::CHAR_W-1:0] ch,
    input  logic                        blank,
    input  logic [vigc_pkg::OFS_W-1:0]  key_entry,
    input  logic                        decrypt,
    output logic [vigc_pkg::CHAR_W-1:0] char_out
);

    logic [vigc_pkg::CHAR_W-1:0] upper;
    logic [vigc_pkg::OFS_W-1:0]  k;
    logic signed [7:0]           v;
    logic signed [7:0]           s;

    always_comb
    begin
        upper = ((ch >= vigc_pkg::CH_LC_A) && (ch <= vigc_pkg::CH_LC_Z))
              ? (ch - vigc_pkg::CASE_GAP) : ch;
        k = (key_entry >= vigc_pkg::ALPHA) ? (key_entry - vigc_pkg::ALPHA) : key_entry;
        v = signed'({1'b0, upper}) - signed'({1'b0, vigc_pkg::CH_A});
        if (decrypt)
        begin
            s = v - signed'({3'b000, k}) + signed'({3'b000, vigc_pkg::ALPHA});
        end
        else
        begin
            s = v + signed'({3'b000, k});
        end
        char_out = blank ? ch : vigc_pkg::mod26_char(s);
    end

endmodule

FILE: rtl/vigenere_offset_cipher.sv
// Streaming key-offset cipher top level: position tracking, key table, output stage.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: char_in, start_of_message, key_slot, key_offset
//                                   tuser: op
//  m_*      out  m_tvalid/m_tready  tdata: char_out
//  cfg_*    in   cfg_we             cfg_addr selects register, cfg_wdata value
//
// One item per cycle unless the output stalls; a result passes the middle and output stages.
// The key table read is issued at accept; the middle stage uses its registered data.
// Key writes give no result. Reset does not clear the key table.
// Reset clears the key position, pipeline valids and decrypt mode and sets key length to 1.
// A stalled output holds the middle stage, then the input side.
module vigenere_offset_cipher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [6:0] char_in, [7] start_of_message, [15:8] key_slot, [20:16] key_offset
    input  logic [vigc_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] op
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [6:0] char_out
    output logic [vigc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_addr,
    input  logic [vigc_pkg::LEN_W-1:0]          cfg_wdata
);

    logic                           decrypt_mode_reg;
    logic [vigc_pkg::LEN_W-1:0]     key_length_reg;
    logic [vigc_pkg::KEY_AW-1:0]    pos_reg, pos_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic [vigc_pkg::CHAR_W-1:0]    s1_ch_reg;
    logic                           s1_blank_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [vigc_pkg::CHAR_W-1:0]    out_ch_reg;

    logic                           accept;
    logic                           is_char;
    logic [vigc_pkg::CHAR_W-1:0]    ch;
    logic                           start;
    logic                           blank;
    logic [vigc_pkg::KEY_AW-1:0]    rd_addr;
    logic [vigc_pkg::LEN_W-1:0]     len_eff;
    logic [vigc_pkg::LEN_W-1:0]     addr_inc;
    logic                           s1_adv;
    logic                           rd_en;
    vigc_pkg::key_wr_t              key_wr;
    logic [vigc_pkg::OFS_W-1:0]     key_entry;
    logic [vigc_pkg::CHAR_W-1:0]    shift_out;

    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;
    assign is_char  = (s_tuser == vigc_pkg::OP_CHAR);
    assign ch       = s_tdata[6:0];
    assign start    = s_tdata[7];
    assign blank    = vigc_pkg::is_blank(ch);
    assign rd_addr  = start ? '0 : pos_reg;
    assign rd_en    = accept && is_char;

    always_comb
    begin
        key_wr.en   = accept && !is_char && (32'(s_tdata[15:8]) < vigc_pkg::KEY_DEPTH);
        key_wr.addr = vigc_pkg::KEY_AW'(s_tdata[15:8]);
        key_wr.data = s_tdata[20:16];
    end

    always_comb
    begin
        priority if (key_length_reg == '0)
            len_eff = vigc_pkg::LEN_W'(1);
        else if (key_length_reg > vigc_pkg::KEY_DEPTH_LEN)
            len_eff = vigc_pkg::KEY_DEPTH_LEN;
        else
            len_eff = key_length_reg;
        addr_inc = vigc_pkg::LEN_W'(rd_addr) + vigc_pkg::LEN_W'(1);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (rd_en)
        begin
            if (!blank)
            begin
                pos_next = (addr_inc >= len_eff) ? '0 : vigc_pkg::KEY_AW'(addr_inc);
            end
            else if (start)
            begin
                pos_next = '0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg <= 1'b0;
            key_length_reg   <= vigc_pkg::LEN_W'(1);
            pos_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (vigc_pkg::cfg_reg_t'(cfg_addr))
                    vigc_pkg::CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_wdata[0];
                    vigc_pkg::CFG_KEY_LENGTH:   key_length_reg   <= cfg_wdata;
                endcase
            end
            pos_reg       <= pos_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_ch_reg    <= ch;
            s1_blank_reg <= blank;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_ch_reg <= shift_out;
        end
    end

    vigc_key_ram u_key_ram (
        .clk     (clk),
        .wr      (key_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_entry)
    );

    vigc_shift u_shift (
        .ch        (s1_ch_reg),
        .blank     (s1_blank_reg),
        .key_entry (key_entry),
        .decrypt   (decrypt_mode_reg),
        .char_out  (shift_out)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ch_reg};

endmodule

FILE: rtl/vigc_checker.sv
// Port-level checks for the offset cipher, bound to the top level.
module vigc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [vigc_pkg::OUT_DATA_W-1:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    a_out_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7] == 1'b0))
        else $error("output character not 7-bit");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind vigenere_offset_cipher vigc_checker u_vigc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: bench/tb_top.sv
// Self-checking bench for the offset cipher: directed and random items against a bench predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int LETTERS     = 26;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 6;
    localparam int SEG_ITEMS   = 100;
    localparam int CYCLE_LIMIT = 400000;

    logic                              clk;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [vigc_pkg::IN_DATA_W-1:0]    s_tdata   = '0;
    logic [0:0]                        s_tuser   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [vigc_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                              cfg_we    = 1'b0;
    logic [0:0]                        cfg_addr  = '0;
    logic [vigc_pkg::LEN_W-1:0]        cfg_wdata = '0;

    // bench copy of the cipher state
    logic [vigc_pkg::OFS_W-1:0]  key_tbl [vigc_pkg::KEY_DEPTH];
    logic [vigc_pkg::KEY_AW-1:0] key_pos  = '0;
    logic                        dec_mode = 1'b0;
    logic [vigc_pkg::LEN_W-1:0]  key_len  = vigc_pkg::LEN_W'(1);

    logic [vigc_pkg::CHAR_W-1:0] exp_char_q [$];

    int errors        = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;

    vigenere_offset_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int eff_len();
        if (key_len == '0)
            return 1;
        if (key_len > vigc_pkg::KEY_DEPTH_LEN)
            return vigc_pkg::KEY_DEPTH;
        return int'(key_len);
    endfunction

    // apply one accepted item to the bench state, queue the character it yields
    function automatic void cipher_step(input vigc_pkg::op_t op,
                                        input logic [vigc_pkg::CHAR_W-1:0] ch,
                                        input logic som,
                                        input logic [vigc_pkg::KEY_AW-1:0] slot,
                                        input logic [vigc_pkg::OFS_W-1:0] ofs);
        logic [vigc_pkg::CHAR_W-1:0] c;
        int v;
        int k;
        int r;
        if (op == vigc_pkg::OP_KEY)
        begin
            key_tbl[slot] = ofs;
            return;
        end
        if (som)
            key_pos = '0;
        if (ch == vigc_pkg::CH_SPACE || ch == vigc_pkg::CH_LF || ch == vigc_pkg::CH_CR)
        begin
            exp_char_q.push_back(ch);
            return;
        end
        c = ch;
        if (c >= vigc_pkg::CH_LC_A && c <= vigc_pkg::CH_LC_Z)
            c = c - vigc_pkg::CASE_GAP;
        v = int'(c) - int'(vigc_pkg::CH_A);
        k = int'(key_tbl[key_pos]) % LETTERS;
        if (dec_mode)
            r = (v - k + LETTERS) % LETTERS;
        else
            r = (v + k) % LETTERS;
        exp_char_q.push_back(vigc_pkg::CHAR_W'(r + int'(vigc_pkg::CH_A)));
        if (int'(key_pos) + 1 >= eff_len())
            key_pos = '0;
        else
            key_pos = key_pos + 1'b1;
    endfunction

    task automatic send_item(input vigc_pkg::op_t op, input logic [vigc_pkg::CHAR_W-1:0] ch,
                             input logic som, input logic [vigc_pkg::KEY_AW-1:0] slot,
                             input logic [vigc_pkg::OFS_W-1:0] ofs);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, ofs, slot, som, ch};
        do
            @(posedge clk);
        while (!s_tready);
        cipher_step(op, ch, som, slot, ofs);
    endtask

    // stop sending and wait for every queued result plus pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (exp_char_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input vigc_pkg::cfg_reg_t idx,
                             input logic [vigc_pkg::LEN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == vigc_pkg::CFG_DECRYPT_MODE)
            dec_mode = value[0];
        else
            key_len = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [vigc_pkg::CHAR_W-1:0] rand_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return vigc_pkg::CHAR_W'($urandom_range(int'(vigc_pkg::CH_A),
                                                    int'(vigc_pkg::CH_A) + LETTERS - 1));
        if (sel < 60)
            return vigc_pkg::CHAR_W'($urandom_range(int'(vigc_pkg::CH_LC_A),
                                                    int'(vigc_pkg::CH_LC_Z)));
        if (sel < 65)
            return vigc_pkg::CH_SPACE;
        if (sel < 70)
            return vigc_pkg::CH_LF;
        if (sel < 75)
            return vigc_pkg::CH_CR;
        return vigc_pkg::CHAR_W'($urandom);
    endfunction

    function automatic logic [vigc_pkg::LEN_W-1:0] pick_len();
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return vigc_pkg::LEN_W'(1);
            2: return vigc_pkg::KEY_DEPTH_LEN;
            3: return vigc_pkg::LEN_W'($urandom_range(vigc_pkg::KEY_DEPTH + 1, 511));
            4: return vigc_pkg::LEN_W'(vigc_pkg::KEY_DEPTH - 1);
            default: return vigc_pkg::LEN_W'($urandom_range(2, 20));
        endcase
    endfunction

    task automatic send_random_item();
        if ($urandom_range(0, 99) < 15)
            send_item(vigc_pkg::OP_KEY, vigc_pkg::CHAR_W'($urandom), 1'($urandom),
                      vigc_pkg::KEY_AW'($urandom), vigc_pkg::OFS_W'($urandom));
        else
            send_item(vigc_pkg::OP_CHAR, rand_char(), ($urandom_range(0, 19) == 0),
                      vigc_pkg::KEY_AW'($urandom), vigc_pkg::OFS_W'($urandom));
    endtask

    task automatic test_directed();
        send_item(vigc_pkg::OP_KEY, 7'h00, 1'b1, 8'd0, 5'd3);    // start flag on a key write
        send_item(vigc_pkg::OP_CHAR, 7'h41, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, 7'h7A, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, 7'h5B, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, vigc_pkg::CH_SPACE, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, vigc_pkg::CH_LF, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, vigc_pkg::CH_CR, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, 7'h00, 1'b0, 8'hFF, 5'd31);
        send_item(vigc_pkg::OP_CHAR, 7'h7F, 1'b1, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_KEY, 7'h7F, 1'b0, 8'd0, 5'd31);   // offset above 25
        send_item(vigc_pkg::OP_CHAR, 7'h61, 1'b0, 8'd0, 5'd0);
        wait_idle();
        cfg_write(vigc_pkg::CFG_DECRYPT_MODE, vigc_pkg::LEN_W'(1));
        send_item(vigc_pkg::OP_CHAR, 7'h41, 1'b1, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, 7'h00, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, 7'h7F, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_KEY, 7'h00, 1'b0, 8'd1, 5'd0);
        send_item(vigc_pkg::OP_KEY, 7'h00, 1'b0, 8'd2, 5'd25);
        wait_idle();
        cfg_write(vigc_pkg::CFG_KEY_LENGTH, vigc_pkg::LEN_W'(3));
        send_item(vigc_pkg::OP_CHAR, 7'h42, 1'b1, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, 7'h43, 1'b0, 8'd0, 5'd0);
        wait_idle();
        // length now below the position
        cfg_write(vigc_pkg::CFG_KEY_LENGTH, vigc_pkg::LEN_W'(1));
        send_item(vigc_pkg::OP_CHAR, 7'h45, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_CHAR, 7'h46, 1'b0, 8'd0, 5'd0);
        send_item(vigc_pkg::OP_KEY, 7'h00, 1'b0, 8'd255, 5'd17);
        wait_idle();
    endtask

    // fill every slot so no later read hits an unwritten entry
    task automatic test_key_load();
        for (int i = 0; i < vigc_pkg::KEY_DEPTH; i++)
            send_item(vigc_pkg::OP_KEY, vigc_pkg::CHAR_W'($urandom), 1'($urandom),
                      vigc_pkg::KEY_AW'(i), vigc_pkg::OFS_W'($urandom));
        wait_idle();
    endtask

    task automatic test_random(input int sp, input int rp, input int segs);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        for (int s = 0; s < segs; s++)
        begin
            wait_idle();
            cfg_write(vigc_pkg::CFG_DECRYPT_MODE, vigc_pkg::LEN_W'($urandom_range(0, 1)));
            cfg_write(vigc_pkg::CFG_KEY_LENGTH, pick_len());
            for (int i = 0; i < SEG_ITEMS; i++)
                send_random_item();
        end
        wait_idle();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_idle();
        cfg_write(vigc_pkg::CFG_KEY_LENGTH, vigc_pkg::LEN_W'($urandom_range(2, 40)));
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(vigc_pkg::OP_CHAR, rand_char(), (i == 0), vigc_pkg::KEY_AW'($urandom),
                      vigc_pkg::OFS_W'($urandom));
        wait_idle();
    endtask

    always @(posedge clk)
    begin : rx_check
        logic [vigc_pkg::CHAR_W-1:0] exp_ch;
        if (m_tvalid && m_tready)
        begin
            if (exp_char_q.size() == 0)
            begin
                $error("char_out: unexpected item, actual %h", m_tdata[vigc_pkg::CHAR_W-1:0]);
                errors++;
            end
            else
            begin
                exp_ch = exp_char_q.pop_front();
                if (m_tdata[vigc_pkg::CHAR_W-1:0] !== exp_ch)
                begin
                    $error("char_out: expected %h actual %h", exp_ch,
                           m_tdata[vigc_pkg::CHAR_W-1:0]);
                    errors++;
                end
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 31;
        recv_idle_pct = 82;
        test_directed();
        test_key_load();
        test_random(31, 82, 5);
        test_random(82, 31, 5);
        test_output_stall();
        test_random(0, 0, 3);
        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
